### src/wps_pkg.sv
package wps_pkg;

	localparam int HDR_LEN       = 44;
	localparam int RIFF_OVERHEAD = 36;

	// header byte offsets with special handling
	localparam logic [5:0] OFF_SIZE0    = 6'd4;
	localparam logic [5:0] OFF_SIZE3    = 6'd7;
	localparam logic [5:0] OFF_CHANNELS = 6'd22;
	localparam logic [5:0] OFF_RATE0    = 6'd24;
	localparam logic [5:0] OFF_RATE3    = 6'd27;
	localparam logic [5:0] OFF_BITS     = 6'd34;
	localparam logic [5:0] OFF_DSIZE0   = 6'd40;
	localparam logic [5:0] HDR_LAST     = 6'(HDR_LEN - 1);

	localparam logic [7:0] CH_MONO    = 8'd1;
	localparam logic [7:0] CH_STEREO  = 8'd2;
	localparam logic [7:0] BITS_NARROW = 8'd8;
	localparam logic [7:0] BITS_WIDE   = 8'd16;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE         = 4'd0,
		ERR_RIFF         = 4'd1,
		ERR_WAVE         = 4'd2,
		ERR_FMT          = 4'd3,
		ERR_CHUNK_LEN    = 4'd4,
		ERR_NOT_PCM      = 4'd5,
		ERR_CHANNELS     = 4'd6,
		ERR_BITS         = 4'd7,
		ERR_DATA_LABEL   = 4'd8,
		ERR_SIZE         = 4'd9,
		ERR_NOT_MULTIPLE = 4'd10
	} err_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		err_t        err;
		logic        stereo;
		logic        wide;
		logic [31:0] rate;
		logic [31:0] frames;
		logic [15:0] sample;
		logic        last;
	} result_t;

	// error raised when a fixed header byte differs from its expected value
	function automatic err_t fail_code(input logic [5:0] off);
		err_t code;
		case (off)
			6'd0, 6'd1, 6'd2, 6'd3:     code = ERR_RIFF;
			6'd8, 6'd9, 6'd10, 6'd11:   code = ERR_WAVE;
			6'd12, 6'd13, 6'd14, 6'd15: code = ERR_FMT;
			6'd16, 6'd17, 6'd18, 6'd19: code = ERR_CHUNK_LEN;
			6'd20, 6'd21:               code = ERR_NOT_PCM;
			6'd23:                      code = ERR_CHANNELS;
			6'd35:                      code = ERR_BITS;
			6'd36, 6'd37, 6'd38, 6'd39: code = ERR_DATA_LABEL;
			default:                    code = ERR_NONE;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] want_byte(input logic [5:0] off);
		logic [7:0] v;
		case (off)
			6'd0:    v = 8'h52; // R
			6'd1:    v = 8'h49; // I
			6'd2:    v = 8'h46; // F
			6'd3:    v = 8'h46; // F
			6'd8:    v = 8'h57; // W
			6'd9:    v = 8'h41; // A
			6'd10:   v = 8'h56; // V
			6'd11:   v = 8'h45; // E
			6'd12:   v = 8'h66; // f
			6'd13:   v = 8'h6d; // m
			6'd14:   v = 8'h74; // t
			6'd15:   v = 8'h20; // space
			6'd16:   v = 8'h10; // fmt chunk length 16
			6'd20:   v = 8'h01; // PCM
			6'd36:   v = 8'h64; // d
			6'd37:   v = 8'h61; // a
			6'd38:   v = 8'h74; // t
			6'd39:   v = 8'h61; // a
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

### src/wps_in_reg.sv
module wps_in_reg
	import wps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     [7:0] stream_byte,
	input  logic     file_start,
	output logic     in_ready,
	input  logic     advance,
	output logic     item_valid,
	output in_item_t item
);

	logic     valid_s1;
	in_item_t item_s1;

	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data  <= stream_byte;
			item_s1.start <= file_start;
		end
	end

endmodule

### src/wps_parse.sv
module wps_parse
	import wps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output logic     res_valid,
	output result_t  res
);

	phase_t      phase_q, cur_phase, n_phase;
	logic [5:0]  off_q, cur_off, n_off, off_c;
	logic [31:0] exp_q, cur_exp, n_exp, exp_m;
	logic [31:0] chunk_q, cur_chunk, n_chunk, chunk_m;
	logic [31:0] rate_q, cur_rate, n_rate, rate_m;
	logic        st_q, cur_st, n_st, st_m;
	logic        wd_q, cur_wd, n_wd, wd_m;
	logic [7:0]  low_q, cur_low, n_low;
	logic [31:0] left_q, cur_left, n_left, left_dec;
	logic [7:0]  b;
	logic [4:0]  lane_bit;
	logic [31:0] frames;
	logic        mask_hit;
	err_t        fc, hdr_err;

	assign b = item.data;

	// a start byte sees cleared state and the header phase
	always_comb begin
		if (item.start) begin
			cur_phase = PH_HEADER;
			cur_off   = '0;
			cur_exp   = '0;
			cur_chunk = '0;
			cur_rate  = '0;
			cur_st    = 1'b0;
			cur_wd    = 1'b0;
			cur_low   = '0;
			cur_left  = '0;
		end else begin
			cur_phase = phase_q;
			cur_off   = off_q;
			cur_exp   = exp_q;
			cur_chunk = chunk_q;
			cur_rate  = rate_q;
			cur_st    = st_q;
			cur_wd    = wd_q;
			cur_low   = low_q;
			cur_left  = left_q;
		end
	end

	// header field accumulation and checks
	always_comb begin
		off_c    = (cur_off > HDR_LAST) ? HDR_LAST : cur_off;
		lane_bit = {off_c[1:0], 3'b000};
		exp_m    = cur_exp;
		rate_m   = cur_rate;
		chunk_m  = cur_chunk;
		if (off_c >= OFF_SIZE0 && off_c <= OFF_SIZE3)
			exp_m[lane_bit +: 8] = cur_exp[lane_bit +: 8] | b;
		if (off_c >= OFF_RATE0 && off_c <= OFF_RATE3)
			rate_m[lane_bit +: 8] = cur_rate[lane_bit +: 8] | b;
		if (off_c >= OFF_DSIZE0)
			chunk_m[lane_bit +: 8] = cur_chunk[lane_bit +: 8] | b;
		st_m = (off_c == OFF_CHANNELS) ? (b == CH_STEREO) : cur_st;
		wd_m = (off_c == OFF_BITS) ? (b == BITS_WIDE) : cur_wd;

		mask_hit = ((cur_st | cur_wd) & chunk_m[0]) | ((cur_st & cur_wd) & chunk_m[1]);
		if (cur_st && cur_wd)
			frames = chunk_m >> 2;
		else if (cur_st || cur_wd)
			frames = chunk_m >> 1;
		else
			frames = chunk_m;

		fc = fail_code(off_c);
		priority if (fc != ERR_NONE && b != want_byte(off_c))
			hdr_err = fc;
		else if (off_c == OFF_CHANNELS && b != CH_MONO && b != CH_STEREO)
			hdr_err = ERR_CHANNELS;
		else if (off_c == OFF_BITS && b != BITS_NARROW && b != BITS_WIDE)
			hdr_err = ERR_BITS;
		else if (off_c == HDR_LAST && (exp_m - 32'(RIFF_OVERHEAD)) != chunk_m)
			hdr_err = ERR_SIZE;
		else if (off_c == HDR_LAST && mask_hit)
			hdr_err = ERR_NOT_MULTIPLE;
		else
			hdr_err = ERR_NONE;
	end

	assign left_dec = cur_left - 32'd1;

	// next state
	always_comb begin
		n_phase = cur_phase;
		n_off   = cur_off;
		n_exp   = cur_exp;
		n_chunk = cur_chunk;
		n_rate  = cur_rate;
		n_st    = cur_st;
		n_wd    = cur_wd;
		n_low   = cur_low;
		n_left  = cur_left;
		unique case (cur_phase)
			PH_HEADER: begin
				if (hdr_err != ERR_NONE) begin
					n_phase = PH_IDLE;
					n_st    = 1'b0;
					n_wd    = 1'b0;
				end else begin
					n_exp   = exp_m;
					n_rate  = rate_m;
					n_chunk = chunk_m;
					n_st    = st_m;
					n_wd    = wd_m;
					if (off_c != HDR_LAST) begin
						n_off = off_c + 6'd1;
					end else begin
						n_off   = '0;
						n_left  = chunk_m;
						n_phase = (chunk_m == '0) ? PH_IDLE : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (cur_left == '0) begin
					n_phase = PH_IDLE;
				end else begin
					n_left = left_dec;
					if (cur_wd && left_dec[0])
						n_low = b;
					else if (left_dec == '0)
						n_phase = PH_IDLE;
				end
			end
			default: n_phase = PH_IDLE;
		endcase
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		unique case (cur_phase)
			PH_HEADER: begin
				if (hdr_err != ERR_NONE) begin
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					res.err   = hdr_err;
				end else if (off_c == HDR_LAST) begin
					res_valid  = 1'b1;
					res.kind   = KIND_HEADER;
					res.stereo = cur_st;
					res.wide   = cur_wd;
					res.rate   = rate_m;
					res.frames = frames;
					res.last   = (chunk_m == '0);
				end
			end
			PH_DATA: begin
				if (cur_left != '0 && !(cur_wd && left_dec[0])) begin
					res_valid  = 1'b1;
					res.kind   = KIND_SAMPLE;
					res.stereo = cur_st;
					res.wide   = cur_wd;
					res.sample = cur_wd ? {b, cur_low} : {8'h00, b};
					res.last   = (left_dec == '0);
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			off_q   <= '0;
			exp_q   <= '0;
			chunk_q <= '0;
			rate_q  <= '0;
			st_q    <= 1'b0;
			wd_q    <= 1'b0;
			low_q   <= '0;
			left_q  <= '0;
		end else if (step) begin
			phase_q <= n_phase;
			off_q   <= n_off;
			exp_q   <= n_exp;
			chunk_q <= n_chunk;
			rate_q  <= n_rate;
			st_q    <= n_st;
			wd_q    <= n_wd;
			low_q   <= n_low;
			left_q  <= n_left;
		end
	end

endmodule

### src/wps_out_reg.sv
module wps_out_reg
	import wps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_ready,
	output logic    out_valid,
	output logic    space,
	output result_t res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign space     = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			res_q <= res;
		end
	end

endmodule

### src/wav_pcm_stream_parser_top.sv
// Canonical 44-byte RIFF WAVE (PCM) stream parser.
// Input channel: one file byte per request (stream_byte), with file_start
// marking byte zero of a new file; in_valid / in_ready handshake.
// Output channel: one result per request on out_valid / out_ready:
// result_kind header info, sample or error, with the matching fields.
// A header result follows byte 43, then one sample per complete sample
// (16-bit samples joined little-endian); last_item marks the final one.
// The first header error is reported once; bytes are then dropped until
// the next file_start. Bytes past the data are dropped the same way.
// An accepted byte lands in the input register; the parse stage then fills
// the result register from it.
// Throughput: one byte per cycle unless the output stalls, set by the
// single parse stage updating header and data state for every byte.
// Reset: idle, all bytes dropped until a byte with file_start arrives.
// Stall: while a result waits, the input register still takes one more
// byte; in_ready drops only when both registers are full.
module wav_pcm_stream_parser_top
	import wps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [3:0]  error_code,
	output logic        is_stereo,
	output logic        is_wide,
	output logic [31:0] sample_rate,
	output logic [31:0] frame_count,
	output logic [15:0] sample_value,
	output logic        last_item
);

	in_item_t item;
	logic     item_valid;
	logic     space;
	logic     step;
	logic     res_valid;
	result_t  res;
	result_t  res_q;

	assign step = item_valid && space;

	wps_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.stream_byte(stream_byte),
		.file_start (file_start),
		.in_ready   (in_ready),
		.advance    (space),
		.item_valid (item_valid),
		.item       (item)
	);

	wps_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item),
		.res_valid(res_valid),
		.res      (res)
	);

	wps_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res_valid),
		.res      (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.space    (space),
		.res_q    (res_q)
	);

	assign result_kind  = res_q.kind;
	assign error_code   = res_q.err;
	assign is_stereo    = res_q.stereo;
	assign is_wide      = res_q.wide;
	assign sample_rate  = res_q.rate;
	assign frame_count  = res_q.frames;
	assign sample_value = res_q.sample;
	assign last_item    = res_q.last;

	// a ready receiver never blocks the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result_kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error kind and error code disagree");

	a_sample_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_SAMPLE) |->
			(sample_rate == '0 && frame_count == '0))
		else $error("sample result carries header fields");

	a_empty_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_HEADER && last_item) |-> (frame_count == '0))
		else $error("last header result with nonzero frame count");

endmodule
